// ===== design/clwd_pkg.sv =====
// Shared types, codes and reset constants for the crash-loop watchdog supervisor.
// No dependencies; every other design file imports this package.
package clwd_pkg;

    // Event codes carried in the opcode field
    localparam logic [2:0] OP_BOOT    = 3'd0;
    localparam logic [2:0] OP_POLL    = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_FAULT   = 3'd3;
    localparam logic [2:0] OP_BOOTSEL = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRASH_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TIME = 2'd2;
    localparam int CFG_DATA_W = 40;

    // Register reset values
    localparam logic [7:0]  CRASH_LIMIT_RST = 8'd3;
    localparam logic [31:0] STUCK_TIME_RST  = 32'd5_000_000;
    localparam logic [39:0] STABLE_TIME_RST = 40'd60_000_000;

    // Scratch record markers
    localparam logic [31:0] MAGIC_WORD  = 32'h4e54_4231;
    localparam logic [31:0] ESCAPE_MARK = 32'hE5CA_9E00;
    localparam logic [7:0]  COUNT_MAX   = 8'd255;

    typedef struct packed {
        logic [7:0]  crash_limit;
        logic [31:0] stuck_time_us;
        logic [39:0] stable_time_us;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        was_watchdog_reset;
        logic [63:0] time_us;
        logic [31:0] core1_loop_count;
        logic [31:0] stacked_pc;
        logic [31:0] stacked_lr;
        logic        faulting_core;
    } t_item;

    typedef struct packed {
        logic        feed_watchdog;
        logic        enter_bootsel;
        logic        reset_core1;
        logic        wd_reboot;
        logic [7:0]  reboot_count;
        logic        fault_valid;
        logic [31:0] flt_pc;
        logic [31:0] flt_lr;
        logic        flt_core;
        logic        is_stable;
    } t_result;

endpackage

// ===== design/clwd_cfg_regs.sv =====
// Configuration registers of the crash-loop watchdog supervisor.
// Depends on clwd_pkg for register indexes, reset values and t_cfg.
module clwd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [clwd_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [clwd_pkg::CFG_DATA_W-1:0]  i_data,
    output clwd_pkg::t_cfg                   o_cfg
);
    import clwd_pkg::*;

    t_cfg r_cfg;

    // Capture a write beat; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crash_limit    <= CRASH_LIMIT_RST;
            r_cfg.stuck_time_us  <= STUCK_TIME_RST;
            r_cfg.stable_time_us <= STABLE_TIME_RST;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_CRASH_LIMIT: r_cfg.crash_limit    <= i_data[7:0];
                CFG_STUCK_TIME:  r_cfg.stuck_time_us  <= i_data[31:0];
                CFG_STABLE_TIME: r_cfg.stable_time_us <= i_data[39:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/clwd_engine.sv =====
// Supervisor state and single-pass event logic: scratch record, boot report,
// feed decision. Depends on clwd_pkg for codes, markers and the item/result types.
module clwd_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  clwd_pkg::t_item   i_item,
    input  clwd_pkg::t_cfg    i_cfg,
    output clwd_pkg::t_result o_result
);
    import clwd_pkg::*;

    // Persistent record
    logic        r_record_valid, n_record_valid;
    logic [31:0] r_crash_word,   n_crash_word;
    logic [31:0] r_saved_pc,     n_saved_pc;
    logic [31:0] r_saved_lr,     n_saved_lr;
    // Working memory
    logic        r_rep_reboot,   n_rep_reboot;
    logic [7:0]  r_rep_count,    n_rep_count;
    logic        r_rep_fvalid,   n_rep_fvalid;
    logic [31:0] r_rep_pc,       n_rep_pc;
    logic [31:0] r_rep_lr,       n_rep_lr;
    logic        r_rep_core,     n_rep_core;
    logic        r_stable,       n_stable;
    logic [31:0] r_last_loops,   n_last_loops;
    logic [63:0] r_moved_time,   n_moved_time;
    logic        r_fault_seen,   n_fault_seen;
    logic        r_feed_stop,    n_feed_stop;

    // Boot helpers
    logic        escaped;
    logic [31:0] prev_count;
    logic [7:0]  boot_count;
    logic        use_rec;
    logic [31:0] boot_pc;
    logic [31:0] boot_lr;
    logic [7:0]  limit;
    // Poll helpers
    logic [63:0] moved_eff;
    logic [63:0] idle_time;
    logic        core_alive;

    always_comb begin
        escaped    = r_record_valid && (r_crash_word == ESCAPE_MARK);
        prev_count = (r_record_valid && !escaped) ? r_crash_word : 32'd0;
        if (!i_item.was_watchdog_reset) begin
            boot_count = 8'd0;
        end else if (prev_count >= {24'd0, COUNT_MAX}) begin
            boot_count = COUNT_MAX;
        end else begin
            boot_count = prev_count[7:0] + 8'd1;
        end
        use_rec = r_record_valid && (i_item.was_watchdog_reset || escaped);
        boot_pc = use_rec ? r_saved_pc : 32'd0;
        boot_lr = use_rec ? r_saved_lr : 32'd0;
        limit   = (i_cfg.crash_limit == 8'd0) ? 8'd1 : i_cfg.crash_limit;

        moved_eff = (i_item.core1_loop_count != r_last_loops) ? i_item.time_us
                                                              : r_moved_time;
        idle_time = i_item.time_us - moved_eff;
        core_alive = (i_item.core1_loop_count == 32'd0) ||
                     (idle_time < {32'd0, i_cfg.stuck_time_us});
    end

    // Next state and result for the item in the input register
    always_comb begin
        n_record_valid = r_record_valid;
        n_crash_word   = r_crash_word;
        n_saved_pc     = r_saved_pc;
        n_saved_lr     = r_saved_lr;
        n_rep_reboot   = r_rep_reboot;
        n_rep_count    = r_rep_count;
        n_rep_fvalid   = r_rep_fvalid;
        n_rep_pc       = r_rep_pc;
        n_rep_lr       = r_rep_lr;
        n_rep_core     = r_rep_core;
        n_stable       = r_stable;
        n_last_loops   = r_last_loops;
        n_moved_time   = r_moved_time;
        n_fault_seen   = r_fault_seen;
        n_feed_stop    = r_feed_stop;
        o_result       = '0;

        case (i_item.opcode)
            OP_BOOT: begin
                n_rep_reboot   = i_item.was_watchdog_reset;
                n_rep_count    = boot_count;
                n_rep_fvalid   = (boot_pc != 32'd0);
                n_rep_pc       = n_rep_fvalid ? boot_pc : 32'd0;
                n_rep_lr       = n_rep_fvalid ? (boot_lr | 32'd1) : 32'd0;
                n_rep_core     = n_rep_fvalid && boot_lr[0];
                n_stable       = 1'b0;
                n_last_loops   = 32'd0;
                n_moved_time   = 64'd0;
                n_fault_seen   = 1'b0;
                n_feed_stop    = 1'b0;
                n_record_valid = 1'b1;
                // Reaching the limit leaves the escape marker and keeps the fault
                if (boot_count >= limit) begin
                    n_crash_word = ESCAPE_MARK;
                    n_saved_pc   = boot_pc;
                    n_saved_lr   = boot_lr;
                    o_result.enter_bootsel = 1'b1;
                end else begin
                    n_crash_word = {24'd0, boot_count};
                    n_saved_pc   = 32'd0;
                    n_saved_lr   = 32'd0;
                end
            end
            OP_POLL: begin
                n_last_loops = i_item.core1_loop_count;
                n_moved_time = moved_eff;
                if (!r_stable && (i_item.time_us >= {24'd0, i_cfg.stable_time_us})) begin
                    n_stable     = 1'b1;
                    n_crash_word = 32'd0;
                end
                o_result.feed_watchdog = core_alive && !r_fault_seen && !r_feed_stop;
            end
            OP_STOP: begin
                n_feed_stop = 1'b1;
            end
            OP_FAULT: begin
                n_fault_seen = 1'b1;
                n_saved_pc   = i_item.stacked_pc;
                n_saved_lr   = {i_item.stacked_lr[31:1], i_item.faulting_core};
            end
            OP_BOOTSEL: begin
                n_crash_word = 32'd0;
                n_saved_pc   = 32'd0;
                n_saved_lr   = 32'd0;
                o_result.enter_bootsel = 1'b1;
                o_result.reset_core1   = 1'b1;
            end
            default: ;
        endcase

        o_result.wd_reboot    = n_rep_reboot;
        o_result.reboot_count = n_rep_count;
        o_result.fault_valid  = n_rep_fvalid;
        o_result.flt_pc       = n_rep_pc;
        o_result.flt_lr       = n_rep_lr;
        o_result.flt_core     = n_rep_core;
        o_result.is_stable    = n_stable;
    end

    // Commit state when the item moves to the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_valid <= 1'b0;
            r_crash_word   <= 32'd0;
            r_saved_pc     <= 32'd0;
            r_saved_lr     <= 32'd0;
            r_rep_reboot   <= 1'b0;
            r_rep_count    <= 8'd0;
            r_rep_fvalid   <= 1'b0;
            r_rep_pc       <= 32'd0;
            r_rep_lr       <= 32'd0;
            r_rep_core     <= 1'b0;
            r_stable       <= 1'b0;
            r_last_loops   <= 32'd0;
            r_moved_time   <= 64'd0;
            r_fault_seen   <= 1'b0;
            r_feed_stop    <= 1'b0;
        end else if (i_fire) begin
            r_record_valid <= n_record_valid;
            r_crash_word   <= n_crash_word;
            r_saved_pc     <= n_saved_pc;
            r_saved_lr     <= n_saved_lr;
            r_rep_reboot   <= n_rep_reboot;
            r_rep_count    <= n_rep_count;
            r_rep_fvalid   <= n_rep_fvalid;
            r_rep_pc       <= n_rep_pc;
            r_rep_lr       <= n_rep_lr;
            r_rep_core     <= n_rep_core;
            r_stable       <= n_stable;
            r_last_loops   <= n_last_loops;
            r_moved_time   <= n_moved_time;
            r_fault_seen   <= n_fault_seen;
            r_feed_stop    <= n_feed_stop;
        end
    end

endmodule

// ===== design/clwd_res_fifo.sv =====
// Two-entry result queue: circular buffer with read and write pointers.
// Depends on clwd_pkg for t_result.
module clwd_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  clwd_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_space,
    output logic              o_valid,
    output clwd_pkg::t_result o_data
);
    import clwd_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt, n_cnt;

    // Room for a beat when not full or when the head leaves this cycle
    assign o_space = (r_cnt != 2'd2) || i_pop;
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= n_cnt;
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== design/crash_loop_watchdog_supervisor_core.sv =====
// Top level of the crash-loop watchdog supervisor.
// Depends on clwd_pkg, clwd_cfg_regs, clwd_engine and clwd_res_fifo.
//
// Usage:
//   Event channel: i_valid / o_ready with one port per event field. Every
//   event beat yields exactly one result beat on o_valid / i_ready.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; index 0 crash limit, 1 stuck time, 2 stable time. Writes are
//   always taken and belong in idle periods.
//   Flow: an accepted event lands in the input register, is evaluated by the
//   single-pass event logic once the result queue has room and is written to
//   the result queue, whose head drives o_valid and the result fields.
//   Throughput: one event per cycle while the result queue has room; each
//   event is evaluated between the input register and the result queue.
//   Stall: a two-entry result queue holds results while i_ready is low; the
//   input register keeps accepting until the queue and the input register are
//   both full, then o_ready drops.
//   Reset (synchronous, i_rst_n low): scratch record and working state clear
//   to zero, registers return to limit 3, stuck 5 s, stable 60 s, queue empty.
module crash_loop_watchdog_supervisor_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Event channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [2:0]                       i_opcode,
    input  logic                             i_was_watchdog_reset,
    input  logic [63:0]                      i_time_us,
    input  logic [31:0]                      i_core1_loop_count,
    input  logic [31:0]                      i_stacked_pc,
    input  logic [31:0]                      i_stacked_lr,
    input  logic                             i_faulting_core,
    // Result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_feed_watchdog,
    output logic                             o_enter_bootsel,
    output logic                             o_reset_core1,
    output logic                             o_wd_reboot,
    output logic [7:0]                       o_reboot_count,
    output logic                             o_fault_valid,
    output logic [31:0]                      o_flt_pc,
    output logic [31:0]                      o_flt_lr,
    output logic                             o_flt_core,
    output logic                             o_is_stable,
    // Config channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [clwd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [clwd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import clwd_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_vld;
    t_result res_next;
    t_result res_head;
    logic    q_space;
    logic    q_pop;
    logic    fire;
    logic    in_accept;

    assign o_cfg_ready = 1'b1;

    clwd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Evaluate the held beat whenever the queue can take its result
    assign fire      = r_in_vld && q_space;
    assign o_ready   = !r_in_vld || fire;
    assign in_accept = i_valid && o_ready;
    assign q_pop     = o_valid && i_ready;

    // Input register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    // Input register: payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.opcode             <= i_opcode;
            r_item.was_watchdog_reset <= i_was_watchdog_reset;
            r_item.time_us            <= i_time_us;
            r_item.core1_loop_count   <= i_core1_loop_count;
            r_item.stacked_pc         <= i_stacked_pc;
            r_item.stacked_lr         <= i_stacked_lr;
            r_item.faulting_core      <= i_faulting_core;
        end
    end

    clwd_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (res_next)
    );

    clwd_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res_next),
        .i_pop   (q_pop),
        .o_space (q_space),
        .o_valid (o_valid),
        .o_data  (res_head)
    );

    assign o_feed_watchdog = res_head.feed_watchdog;
    assign o_enter_bootsel = res_head.enter_bootsel;
    assign o_reset_core1   = res_head.reset_core1;
    assign o_wd_reboot     = res_head.wd_reboot;
    assign o_reboot_count  = res_head.reboot_count;
    assign o_fault_valid   = res_head.fault_valid;
    assign o_flt_pc        = res_head.flt_pc;
    assign o_flt_lr        = res_head.flt_lr;
    assign o_flt_core      = res_head.flt_core;
    assign o_is_stable     = res_head.is_stable;

`ifndef SYNTHESIS
    // An accepted beat is held in the input register in the next cycle
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_vld)
        else $error("accepted event not held in input register");

    // The event side stalls only with a beat waiting on a full queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_vld && !q_space && o_valid))
        else $error("event stall without a full result queue");

    // A core reset request always comes with the bootsel escape
    a_core1_bootsel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reset_core1) |-> (o_enter_bootsel && !o_feed_watchdog))
        else $error("core reset without bootsel escape");

    // Without a fault record the fault fields read as zero
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_fault_valid) |->
            (o_flt_pc == 32'd0 && o_flt_lr == 32'd0 && !o_flt_core))
        else $error("fault fields set without fault record");
`endif

endmodule
